// File: rtl/core/mspb_pkg.sv
// shared types, slicing tables and correlator function for the mode s demodulator
`timescale 1ns / 1ps
`default_nettype none
package mspb_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int NUM_TRY    = 5;
    localparam int NUM_BYTES  = 14;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;
    localparam int NUM_KIND   = 5;
    localparam int PRE_LEN    = 19;
    localparam int TRY_W      = 3;

    localparam logic [2:0] KIND_A = 3'd0;
    localparam logic [2:0] KIND_B = 3'd1;
    localparam logic [2:0] KIND_C = 3'd2;
    localparam logic [2:0] KIND_D = 3'd3;
    localparam logic [2:0] KIND_E = 3'd4;

    localparam logic [TRY_W-1:0] TRY_LAST = 3'd4;

    localparam logic [4:0] DF_SHORT0 = 5'd0;
    localparam logic [4:0] DF_SHORT4 = 5'd4;
    localparam logic [4:0] DF_SHORT5 = 5'd5;
    localparam logic [4:0] DF_SHORT11 = 5'd11;

    // sample offset of each bit inside a byte, per bit phase
    localparam logic [4:0] SLOT_OFF [5][8] = '{
        '{5'd0, 5'd2, 5'd4, 5'd7, 5'd9, 5'd12, 5'd14, 5'd16},
        '{5'd0, 5'd2, 5'd5, 5'd7, 5'd9, 5'd12, 5'd14, 5'd17},
        '{5'd0, 5'd2, 5'd5, 5'd7, 5'd10, 5'd12, 5'd14, 5'd17},
        '{5'd0, 5'd3, 5'd5, 5'd7, 5'd10, 5'd12, 5'd15, 5'd17},
        '{5'd0, 5'd3, 5'd5, 5'd8, 5'd10, 5'd12, 5'd15, 5'd17}
    };

    // correlator kind of each bit inside a byte, per bit phase
    localparam logic [2:0] SLOT_COR [5][8] = '{
        '{3'd0, 3'd2, 3'd4, 3'd1, 3'd3, 3'd0, 3'd2, 3'd4},
        '{3'd1, 3'd3, 3'd0, 3'd2, 3'd4, 3'd1, 3'd3, 3'd0},
        '{3'd2, 3'd4, 3'd1, 3'd3, 3'd0, 3'd2, 3'd4, 3'd1},
        '{3'd3, 3'd0, 3'd2, 3'd4, 3'd1, 3'd3, 3'd0, 3'd2},
        '{3'd4, 3'd1, 3'd3, 3'd0, 3'd2, 3'd4, 3'd1, 3'd3}
    };

    typedef struct packed {
        logic [55:0] msg_head;
        logic [55:0] msg_tail;
        logic        long_msg;
    } cand_t;

    typedef cand_t [NUM_TRY-1:0] det_t;

    typedef struct packed {
        logic push;
        logic pop;
    } fifo_ctl_t;

    // sign of one 2.4 msps bit correlator over four samples
    function automatic logic corr_pos(
        input logic [2:0]          kind,
        input logic [SAMPLE_W-1:0] a0,
        input logic [SAMPLE_W-1:0] a1,
        input logic [SAMPLE_W-1:0] a2,
        input logic [SAMPLE_W-1:0] a3
    );
        logic signed [20:0] x0;
        logic signed [20:0] x1;
        logic signed [20:0] x2;
        logic signed [20:0] x3;
        logic signed [20:0] r;
        x0 = signed'({5'b0, a0});
        x1 = signed'({5'b0, a1});
        x2 = signed'({5'b0, a2});
        x3 = signed'({5'b0, a3});
        case (kind)
            KIND_A:  r = 21'sd5 * x0 - 21'sd3 * x1 - 21'sd2 * x2;
            KIND_B:  r = 21'sd4 * x0 - x1 - 21'sd3 * x2;
            KIND_C:  r = 21'sd3 * x0 + x1 - 21'sd4 * x2;
            KIND_D:  r = 21'sd2 * x0 + 21'sd3 * x1 - 21'sd5 * x2;
            KIND_E:  r = x0 + 21'sd5 * x1 - 21'sd5 * x2 - x3;
            default: r = '0;
        endcase
        return r > 21'sd0;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/mspb_if.sv
// valid/ready channels for magnitude samples and message candidates
`timescale 1ns / 1ps
`default_nettype none
interface mspb_sample_if;
    logic        valid;
    logic        ready;
    logic [15:0] sample;
    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface mspb_cand_if;
    logic        valid;
    logic        ready;
    logic [55:0] msg_head;
    logic [55:0] msg_tail;
    logic        long_msg;
    logic [2:0]  try_index;
    logic        last;
    modport source (output valid, output msg_head, output msg_tail, output long_msg,
                    output try_index, output last, input ready);
    modport sink (input valid, input msg_head, input msg_tail, input long_msg,
                  input try_index, input last, output ready);
endinterface
`default_nettype wire

// File: rtl/core/mode_s_preamble_and_bit_slicer_top.sv
// Mode S preamble detector and five-phase PPM bit slicer, top level.
// Takes one 16-bit magnitude sample per cycle into a WINDOW_LEN sample shift
// window; the five correlator signs of each sample position are kept in a parallel
// sign line, so a detection at the oldest position yields all five 112-bit
// candidates from fixed taps in the cycle after the sample that completes it. Each
// detection enters a four-entry queue and leaves as five candidate items, one per
// output handshake (try_index 0..4, last on the fifth). Sample input runs at one
// item per cycle and stalls only while the queue cannot take one more detection.
`timescale 1ns / 1ps
`default_nettype none
module mode_s_preamble_and_bit_slicer_top #(
    parameter int WINDOW_LEN = 300
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    mspb_sample_if.sink     samples,
    mspb_cand_if.source     candidates
);
    logic                              accept;
    logic                              fresh;
    logic                              hit;
    mspb_pkg::det_t                    det;
    mspb_pkg::det_t                    head;
    mspb_pkg::fifo_ctl_t               ctl;
    logic [mspb_pkg::FIFO_CNT_W-1:0]   q_count;
    logic                              pop;

    // room for a detection that may still be pending from the last sample
    assign samples.ready = (q_count + {{(mspb_pkg::FIFO_CNT_W-1){1'b0}}, fresh})
        < mspb_pkg::FIFO_CNT_W'(mspb_pkg::FIFO_DEPTH);
    assign accept   = samples.valid && samples.ready;
    assign ctl.push = hit;
    assign ctl.pop  = pop;

    mspb_front #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .sample (samples.sample),
        .fresh  (fresh),
        .hit    (hit),
        .det    (det)
    );

    mspb_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .wr_data (det),
        .rd_data (head),
        .count   (q_count)
    );

    mspb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_count != '0),
        .head       (head),
        .pop        (pop),
        .cands      (candidates)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.push |-> (q_count < mspb_pkg::FIFO_CNT_W'(mspb_pkg::FIFO_DEPTH)))
        else $error("detection queue overflow");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pop |-> (q_count != '0))
        else $error("pop from empty detection queue");

    a_restart_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (candidates.valid && candidates.ready && candidates.last)
        |=> (candidates.try_index == '0))
        else $error("candidate index did not restart after last");

endmodule
`default_nettype wire

// File: rtl/core/mspb_front.sv
// sample window, correlator sign line, preamble test and candidate slicing
`timescale 1ns / 1ps
`default_nettype none
module mspb_front #(
    parameter int WINDOW_LEN = 300
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            accept,
    input  wire logic [mspb_pkg::SAMPLE_W-1:0]   sample,
    output logic                                 fresh,
    output logic                                 hit,
    output mspb_pkg::det_t                       det
);
    localparam int CORR_LEN = WINDOW_LEN - 4;
    localparam int FILL_W   = $clog2(WINDOW_LEN + 1);

    logic [mspb_pkg::SAMPLE_W-1:0] window_reg [WINDOW_LEN];
    logic [mspb_pkg::NUM_KIND-1:0] corr_reg [CORR_LEN];
    logic [mspb_pkg::NUM_KIND-1:0] corr_new;
    logic [FILL_W-1:0]             fill_reg;
    logic [FILL_W-1:0]             fill_next;
    logic                          fresh_reg;
    logic                          fresh_next;

    always_comb
    begin
        fill_next = fill_reg;
        if (accept && fill_reg != FILL_W'(WINDOW_LEN))
        begin
            fill_next = fill_reg + 1'b1;
        end
        fresh_next = accept && (fill_next == FILL_W'(WINDOW_LEN));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            fresh_reg <= 1'b0;
        end
        else
        begin
            fill_reg  <= fill_next;
            fresh_reg <= fresh_next;
        end
    end

    // signs for the newest full quad of samples, entering at the tail of the line
    always_comb
    begin
        for (int k = 0; k < mspb_pkg::NUM_KIND; k++)
        begin
            corr_new[k] = mspb_pkg::corr_pos(3'(k), window_reg[WINDOW_LEN-4],
                window_reg[WINDOW_LEN-3], window_reg[WINDOW_LEN-2], window_reg[WINDOW_LEN-1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int k = 0; k < WINDOW_LEN - 1; k++)
            begin
                window_reg[k] <= window_reg[k+1];
            end
            window_reg[WINDOW_LEN-1] <= sample;
            for (int k = 0; k < CORR_LEN - 1; k++)
            begin
                corr_reg[k] <= corr_reg[k+1];
            end
            corr_reg[CORR_LEN-1] <= corr_new;
        end
    end

    // preamble test on the oldest samples
    logic [15:0] p [mspb_pkg::PRE_LEN];
    logic [18:0] sum_high;
    logic [16:0] high;
    logic [20:0] sig;
    logic [20:0] noise;
    logic        class_ok;
    logic        edge_ok;
    logic        snr_ok;
    logic        quiet_ok;

    always_comb
    begin
        for (int k = 0; k < mspb_pkg::PRE_LEN; k++)
        begin
            p[k] = window_reg[k];
        end
        edge_ok  = (p[0] < p[1]) && (p[12] > p[13]);
        class_ok = 1'b1;
        sum_high = '0;
        sig      = '0;
        noise    = '0;
        if (p[1] > p[2] && p[2] < p[3] && p[3] > p[4] && p[8] < p[9] && p[9] > p[10]
            && p[10] < p[11])
        begin
            sum_high = 19'(p[1]) + 19'(p[3]) + 19'(p[9]) + 19'(p[11]) + 19'(p[12]);
            sig      = 21'(p[1]) + 21'(p[3]) + 21'(p[9]);
            noise    = 21'(p[5]) + 21'(p[6]) + 21'(p[7]);
        end
        else if (p[1] > p[2] && p[2] < p[3] && p[3] > p[4] && p[8] < p[9] && p[9] > p[10]
            && p[11] < p[12])
        begin
            sum_high = 19'(p[1]) + 19'(p[3]) + 19'(p[9]) + 19'(p[12]);
            sig      = 21'(p[1]) + 21'(p[3]) + 21'(p[9]) + 21'(p[12]);
            noise    = 21'(p[5]) + 21'(p[6]) + 21'(p[7]) + 21'(p[8]);
        end
        else if (p[1] > p[2] && p[2] < p[3] && p[4] > p[5] && p[8] < p[9] && p[10] > p[11]
            && p[11] < p[12])
        begin
            sum_high = 19'(p[1]) + 19'(p[3]) + 19'(p[4]) + 19'(p[9]) + 19'(p[10])
                + 19'(p[12]);
            sig      = 21'(p[1]) + 21'(p[12]);
            noise    = 21'(p[6]) + 21'(p[7]);
        end
        else if (p[1] > p[2] && p[3] < p[4] && p[4] > p[5] && p[9] < p[10] && p[10] > p[11]
            && p[11] < p[12])
        begin
            sum_high = 19'(p[1]) + 19'(p[4]) + 19'(p[10]) + 19'(p[12]);
            sig      = 21'(p[1]) + 21'(p[4]) + 21'(p[10]) + 21'(p[12]);
            noise    = 21'(p[5]) + 21'(p[6]) + 21'(p[7]) + 21'(p[8]);
        end
        else if (p[2] > p[3] && p[3] < p[4] && p[4] > p[5] && p[9] < p[10] && p[10] > p[11]
            && p[11] < p[12])
        begin
            sum_high = 19'(p[1]) + 19'(p[2]) + 19'(p[4]) + 19'(p[10]) + 19'(p[12]);
            sig      = 21'(p[4]) + 21'(p[10]) + 21'(p[12]);
            noise    = 21'(p[6]) + 21'(p[7]) + 21'(p[8]);
        end
        else
        begin
            class_ok = 1'b0;
        end
        high     = sum_high[18:2];
        snr_ok   = {sig[19:0], 1'b0} >= (noise + {noise[19:0], 1'b0});
        quiet_ok = 1'b1;
        for (int k = 5; k <= 8; k++)
        begin
            if (17'(p[k]) >= high)
            begin
                quiet_ok = 1'b0;
            end
        end
        for (int k = 14; k <= 18; k++)
        begin
            if (17'(p[k]) >= high)
            begin
                quiet_ok = 1'b0;
            end
        end
    end

    assign fresh = fresh_reg;
    assign hit   = fresh_reg && edge_ok && class_ok && snr_ok && quiet_ok;

    // every bit is a fixed tap of the sign line
    logic [7:0] msg [mspb_pkg::NUM_TRY][mspb_pkg::NUM_BYTES];
    logic [4:0] df;

    always_comb
    begin
        int pos;
        int ph;
        for (int t = 0; t < mspb_pkg::NUM_TRY; t++)
        begin
            pos = (t == 0) ? 19 : 20;
            ph  = (t == 0) ? 4 : t - 1;
            for (int i = 0; i < mspb_pkg::NUM_BYTES; i++)
            begin
                for (int b = 0; b < 8; b++)
                begin
                    msg[t][i][7-b] = corr_reg[pos + int'(mspb_pkg::SLOT_OFF[ph][b])]
                        [mspb_pkg::SLOT_COR[ph][b]];
                end
                pos = pos + ((ph == 4) ? 20 : 19);
                ph  = (ph == 4) ? 0 : ph + 1;
            end
        end
        for (int t = 0; t < mspb_pkg::NUM_TRY; t++)
        begin
            df = msg[t][0][7:3];
            det[t].long_msg = !(df == mspb_pkg::DF_SHORT0 || df == mspb_pkg::DF_SHORT4
                || df == mspb_pkg::DF_SHORT5 || df == mspb_pkg::DF_SHORT11);
            for (int i = 0; i < 7; i++)
            begin
                det[t].msg_head[55-8*i -: 8] = msg[t][i];
                det[t].msg_tail[55-8*i -: 8] = det[t].long_msg ? msg[t][i+7] : 8'h00;
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/mspb_fifo.sv
// short queue of detections between slicer and candidate sequencer
`timescale 1ns / 1ps
`default_nettype none
module mspb_fifo (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire mspb_pkg::fifo_ctl_t                ctl,
    input  wire mspb_pkg::det_t                     wr_data,
    output mspb_pkg::det_t                          rd_data,
    output logic [mspb_pkg::FIFO_CNT_W-1:0]         count
);
    mspb_pkg::det_t                  mem [mspb_pkg::FIFO_DEPTH];
    logic [mspb_pkg::FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [mspb_pkg::FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [mspb_pkg::FIFO_CNT_W-1:0] count_reg;
    logic [mspb_pkg::FIFO_CNT_W-1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        case ({ctl.push, ctl.pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (ctl.push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (ctl.pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data = mem[rd_ptr_reg];
    assign count   = count_reg;

endmodule
`default_nettype wire

// File: rtl/core/mspb_back.sv
// steps through the five candidates of the detection at the head of the queue
`timescale 1ns / 1ps
`default_nettype none
module mspb_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   head_valid,
    input  wire mspb_pkg::det_t         head,
    output logic                        pop,
    mspb_cand_if.source                 cands
);
    logic [mspb_pkg::TRY_W-1:0] idx_reg;
    logic [mspb_pkg::TRY_W-1:0] idx_next;
    logic                       take;

    always_comb
    begin
        take     = cands.valid && cands.ready;
        pop      = take && (idx_reg == mspb_pkg::TRY_LAST);
        idx_next = idx_reg;
        if (take)
        begin
            idx_next = pop ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

    assign cands.valid     = head_valid;
    assign cands.msg_head  = head[idx_reg].msg_head;
    assign cands.msg_tail  = head[idx_reg].msg_tail;
    assign cands.long_msg  = head[idx_reg].long_msg;
    assign cands.try_index = idx_reg;
    assign cands.last      = (idx_reg == mspb_pkg::TRY_LAST);

endmodule
`default_nettype wire
